@@ rtl/mbsf_pkg.sv @@
package mbsf_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_RUN   = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  localparam logic [1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [1:0] REG_GRID_HEIGHT = 2'd1;
  localparam logic [1:0] REG_PASS_COUNT  = 2'd2;

  typedef struct packed {
    logic accept;
    logic run_init;
    logic win_issue;
    logic div_step;
    logic scr_write;
    logic copy_init;
    logic copy_issue;
    logic next_pass;
    logic end_run;
    logic zero_max;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic [1:0] in_func;
    logic       pass_zero;
    logic       win_last;
    logic       div_last;
    logic       cell_last;
    logic       copy_last;
    logic       pass_last;
  } stat_t;

endpackage

@@ rtl/mbsf_ctrl.sv @@
module mbsf_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  mbsf_pkg::stat_t stat,
  output mbsf_pkg::cmd_t  cmd
);
  import mbsf_pkg::*;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_RDW    = 4'd1;
  localparam logic [3:0] ST_WIN    = 4'd2;
  localparam logic [3:0] ST_DRAIN  = 4'd3;
  localparam logic [3:0] ST_DIV    = 4'd4;
  localparam logic [3:0] ST_SCR    = 4'd5;
  localparam logic [3:0] ST_COPY   = 4'd6;
  localparam logic [3:0] ST_CDRAIN = 4'd7;
  localparam logic [3:0] ST_PEND   = 4'd8;
  localparam logic [3:0] ST_OUT    = 4'd9;

  logic [3:0] state, state_next;
  logic       out_valid_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next     = state;
    cmd            = '0;
    out_valid_next = out_valid & ~out_ready;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          case (stat.in_func)
            FUNC_RUN: begin
              if (stat.pass_zero) begin
                cmd.zero_max = 1'b1;
                state_next   = ST_OUT;
              end else begin
                cmd.run_init = 1'b1;
                state_next   = ST_WIN;
              end
            end
            FUNC_READ: state_next = ST_RDW;
            default:   state_next = ST_OUT;
          endcase
        end
      end
      ST_RDW: state_next = ST_OUT;
      ST_WIN: begin
        cmd.win_issue = 1'b1;
        if (stat.win_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: state_next = ST_DIV;
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_next = ST_SCR;
      end
      ST_SCR: begin
        cmd.scr_write = 1'b1;
        if (stat.cell_last) begin
          cmd.copy_init = 1'b1;
          state_next    = ST_COPY;
        end else begin
          state_next = ST_WIN;
        end
      end
      ST_COPY: begin
        cmd.copy_issue = 1'b1;
        if (stat.copy_last) state_next = ST_CDRAIN;
      end
      ST_CDRAIN: state_next = ST_PEND;
      ST_PEND: begin
        if (stat.pass_last) begin
          cmd.end_run = 1'b1;
          state_next  = ST_OUT;
        end else begin
          cmd.next_pass = 1'b1;
          state_next    = ST_WIN;
        end
      end
      ST_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.load_out   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

@@ rtl/mbsf_datapath.sv @@
module mbsf_datapath #(
  parameter int MAX_WIDTH  = mbsf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = mbsf_pkg::DEF_MAX_HEIGHT
) (
  input  logic            clk,
  input  logic            rst,
  input  mbsf_pkg::cmd_t  cmd,
  output mbsf_pkg::stat_t stat,
  input  logic [8:0]      grid_width,
  input  logic [8:0]      grid_height,
  input  logic [7:0]      pass_count,
  input  logic [1:0]      in_func,
  input  logic [15:0]     in_index,
  input  logic [15:0]     in_value,
  input  logic            in_present,
  output logic [15:0]     read_value,
  output logic [15:0]     field_max
);
  import mbsf_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int NW    = WW + HW;

  logic [15:0] val_mem [DEPTH];
  logic [15:0] scr_mem [DEPTH];
  logic        pres_mem [DEPTH];

  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic [NW-1:0] n_cells;
  logic          in_range;
  logic [AW-1:0] in_addr;

  always_comb begin
    if (grid_width == 9'd0) w_eff = WW'(1);
    else if (32'(grid_width) > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
    else w_eff = WW'(grid_width);
    if (grid_height == 9'd0) h_eff = HW'(1);
    else if (32'(grid_height) > MAX_HEIGHT) h_eff = HW'(MAX_HEIGHT);
    else h_eff = HW'(grid_height);
  end

  assign n_cells  = NW'(w_eff) * NW'(h_eff);
  assign in_range = (32'(in_index) < 32'(n_cells)) && (32'(in_index) < DEPTH);
  assign in_addr  = AW'(in_index);

  logic [1:0]    func_q;
  logic          range_q;
  logic [XW-1:0] x;
  logic [YW-1:0] y;
  logic [AW-1:0] ci;
  logic [3:0]    k;
  logic [7:0]    pc;
  logic [AW-1:0] cc;
  logic [15:0]   val_rd, scr_rd, run_max, last_max;
  logic          pres_rd;
  logic          rd_live_q, ctr_q, center_pres;
  logic [19:0]   dq;
  logic [3:0]    cnt, rem;
  logic [4:0]    dcnt;
  logic          cw_q;
  logic [AW-1:0] cw_addr;

  // window tap position
  logic [1:0]    kx, ky;
  logic [AW-1:0] xoff, yoff, nb_addr;
  logic          nb_ok;

  always_comb begin
    case (k)
      4'd0, 4'd3, 4'd6: kx = 2'd0;
      4'd1, 4'd4, 4'd7: kx = 2'd1;
      default:          kx = 2'd2;
    endcase
    case (k)
      4'd0, 4'd1, 4'd2: ky = 2'd0;
      4'd3, 4'd4, 4'd5: ky = 2'd1;
      default:          ky = 2'd2;
    endcase
    xoff = (kx == 2'd0) ? '1 : ((kx == 2'd2) ? AW'(1) : '0);
    yoff = (ky == 2'd0) ? -AW'(w_eff) : ((ky == 2'd2) ? AW'(w_eff) : '0);
    nb_addr = ci + xoff + yoff;
    nb_ok = ((kx != 2'd0) || (x != '0)) &&
            ((kx != 2'd2) || (32'(x) + 1 < 32'(w_eff))) &&
            ((ky != 2'd0) || (y != '0)) &&
            ((ky != 2'd2) || (32'(y) + 1 < 32'(h_eff)));
  end

  logic          item_wr, rd_en;
  logic [AW-1:0] rd_addr;
  assign item_wr = cmd.accept && (in_func == FUNC_WRITE) && in_range;
  assign rd_en   = cmd.win_issue || (cmd.accept && (in_func == FUNC_READ));
  assign rd_addr = cmd.win_issue ? nb_addr : in_addr;

  always_ff @(posedge clk) begin
    if (cw_q) val_mem[cw_addr] <= scr_rd;
    else if (item_wr) val_mem[in_addr] <= in_value;
    if (rd_en) val_rd <= val_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (item_wr) pres_mem[in_addr] <= in_present;
    if (rd_en) pres_rd <= pres_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.scr_write) scr_mem[ci] <= center_pres ? dq[15:0] : 16'd0;
    if (cmd.copy_issue) scr_rd <= scr_mem[cc];
  end

  // divider trial subtract
  logic [4:0] trial;
  assign trial = {rem, dq[19]};

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_live_q <= 1'b0;
      ctr_q     <= 1'b0;
      cw_q      <= 1'b0;
      last_max  <= 16'd0;
      k         <= 4'd0;
      dcnt      <= 5'd0;
      cnt       <= 4'd0;
    end else begin
      rd_live_q <= cmd.win_issue && nb_ok;
      ctr_q     <= cmd.win_issue && (k == 4'd4);
      cw_q      <= cmd.copy_issue;

      if (cmd.accept) begin
        func_q  <= in_func;
        range_q <= in_range;
      end

      if (cmd.win_issue) k <= k + 4'd1;
      if (rd_live_q && pres_rd) begin
        dq  <= dq + 20'(val_rd);
        cnt <= cnt + 4'd1;
      end
      if (ctr_q) center_pres <= pres_rd;

      if (cmd.div_step) begin
        dcnt <= dcnt + 5'd1;
        if (trial >= 5'(cnt)) begin
          rem <= 4'(trial - 5'(cnt));
          dq  <= {dq[18:0], 1'b1};
        end else begin
          rem <= trial[3:0];
          dq  <= {dq[18:0], 1'b0};
        end
      end

      if (cmd.scr_write) begin
        if (32'(x) + 1 == 32'(w_eff)) begin
          x <= '0;
          y <= y + YW'(1);
        end else begin
          x <= x + XW'(1);
        end
        ci <= ci + AW'(1);
      end

      if (cmd.scr_write || cmd.run_init || cmd.next_pass) begin
        k    <= 4'd0;
        dcnt <= 5'd0;
        cnt  <= 4'd0;
        rem  <= 4'd0;
        dq   <= 20'd0;
      end
      if (cmd.run_init || cmd.next_pass) begin
        x  <= '0;
        y  <= '0;
        ci <= '0;
      end
      if (cmd.run_init) pc <= 8'd0;
      if (cmd.next_pass) pc <= pc + 8'd1;

      if (cmd.copy_init) begin
        cc      <= '0;
        run_max <= 16'd0;
      end
      if (cmd.copy_issue) begin
        cw_addr <= cc;
        cc      <= cc + AW'(1);
      end
      if (cw_q && (scr_rd > run_max)) run_max <= scr_rd;

      if (cmd.end_run) last_max <= run_max;
      if (cmd.zero_max) last_max <= 16'd0;

      if (cmd.load_out) begin
        read_value <= ((func_q == FUNC_READ) && range_q) ? val_rd : 16'd0;
        field_max  <= last_max;
      end
    end
  end

  assign stat.in_func   = in_func;
  assign stat.pass_zero = (pass_count == 8'd0);
  assign stat.win_last  = (k == 4'd8);
  assign stat.div_last  = (dcnt == 5'd19);
  assign stat.cell_last = (32'(ci) + 1 == 32'(n_cells));
  assign stat.copy_last = (32'(cc) + 1 == 32'(n_cells));
  assign stat.pass_last = (pc == pass_count - 8'd1);

`ifndef SYNTH
  a_cnt_le9: assert property (@(posedge clk) disable iff (rst) cnt <= 4'd9)
    else $error("window count above nine");
  a_wr_excl: assert property (@(posedge clk) disable iff (rst) !(cw_q && item_wr))
    else $error("copy write and item write together");
  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> (dcnt < 5'd20))
    else $error("divider overran");
  a_rem_lt: assert property (@(posedge clk) disable iff (rst)
    (cmd.div_step && cnt != 4'd0) |=> (rem < cnt))
    else $error("remainder not below divisor");
`endif

endmodule

@@ rtl/masked_box_smoothing_filter_unit.sv @@
// channel | dir | handshake            | payload
// s_*     | in  | s_tvalid / s_tready  | tdata: cell_index, cell_value, cell_present; tuser: func
// m_*     | out | m_tvalid / m_tready  | tdata: read_value, field_max
// cfg_*   | in  | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Write and other items go straight to output; a read adds a state for the registered memory read.
// Run: pass_count passes over the n cells; per cell 9 window reads
// from the single value port plus a 20-step restoring divider, then a copy sweep.
// Input stalls while a word is in progress; the output register frees the inputs
// while a result waits. Reset clears control, last_max and the config registers; the stores need writing.
module masked_box_smoothing_filter_unit #(
  parameter int MAX_WIDTH  = mbsf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = mbsf_pkg::DEF_MAX_HEIGHT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // cell_index[15:0], cell_value[31:16], cell_present[32]
  input  logic [1:0]  s_tuser,   // func[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // read_value[15:0], field_max[31:16]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data
);
  import mbsf_pkg::*;

  logic [8:0]  grid_width, grid_height;
  logic [7:0]  pass_count;
  cmd_t        cmd;
  stat_t       stat;
  logic [15:0] read_value, field_max;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= 9'd256;
      grid_height <= 9'd256;
      pass_count  <= 8'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_GRID_WIDTH:  grid_width  <= cfg_data;
        REG_GRID_HEIGHT: grid_height <= cfg_data;
        REG_PASS_COUNT:  pass_count  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  mbsf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  mbsf_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .grid_width  (grid_width),
    .grid_height (grid_height),
    .pass_count  (pass_count),
    .in_func     (s_tuser),
    .in_index    (s_tdata[15:0]),
    .in_value    (s_tdata[31:16]),
    .in_present  (s_tdata[32]),
    .read_value  (read_value),
    .field_max   (field_max)
  );

  assign m_tdata = {field_max, read_value};

endmodule
